[src/sik_pkg.sv]
// Shared constants, register codes and the arctangent table of the SCARA kinematics unit.
package sik_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_BASE_HEIGHT = 2'd0,
		REG_INNER_ARM   = 2'd1,
		REG_OUTER_ARM   = 2'd2,
		REG_LINK_WIDTH  = 2'd3
	} cfg_reg_t;

	localparam int CFG_W = 21;

	// Datapath widths of the arctangent unit.
	localparam int CW           = 56;
	localparam int AW           = 34;
	localparam int NORM_STEPS   = 6;
	localparam int CORDIC_STEPS = 30;
	localparam int ATAN_LAT     = NORM_STEPS + 1 + CORDIC_STEPS;

	// Divider and square root steps.
	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 31;

	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	// atan(2^-i) in Q30 radians.
	localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};

endpackage

[src/sik_atan2.sv]
// Pipelined arctangent of y over x: normalization, quadrant fold and vectoring CORDIC.
module sik_atan2 (
	input  logic                               clk,
	input  logic signed [sik_pkg::CW-1:0]      y_in,
	input  logic signed [sik_pkg::CW-1:0]      x_in,
	output logic signed [sik_pkg::AW-1:0]      angle
);

	localparam int NS = sik_pkg::NORM_STEPS;
	localparam int CS = sik_pkg::CORDIC_STEPS;
	localparam int CW = sik_pkg::CW;
	localparam int AW = sik_pkg::AW;

	logic signed [CW-1:0] nx [NS+1];
	logic signed [CW-1:0] ny [NS+1];
	logic                 nz [NS+1];

	logic signed [CW-1:0] cx [CS+1];
	logic signed [CW-1:0] cy [CS+1];
	logic signed [AW-1:0] ca [CS+1];
	logic                 cz [CS+1];

	assign nx[0] = x_in;
	assign ny[0] = y_in;
	assign nz[0] = (x_in == '0) && (y_in == '0);

	// Normalization: double both operands until one magnitude reaches bit 50.
	for (genvar k = 0; k < NS; k++) begin : g_norm
		localparam int SH = 32 >> k;
		logic [CW-1:0] mx, my, mm;
		logic          fits;
		always_comb begin
			mx   = nx[k][CW-1] ? CW'(-nx[k]) : CW'(nx[k]);
			my   = ny[k][CW-1] ? CW'(-ny[k]) : CW'(ny[k]);
			mm   = mx | my;
			fits = (mm >> (51 - SH)) == '0;
		end
		always_ff @(posedge clk) begin
			nx[k+1] <= fits ? (nx[k] <<< SH) : nx[k];
			ny[k+1] <= fits ? (ny[k] <<< SH) : ny[k];
			nz[k+1] <= nz[k];
		end
	end

	// Quadrant fold: rotate by a quarter turn when x is negative.
	always_ff @(posedge clk) begin
		cz[0] <= nz[NS];
		if (nx[NS][CW-1]) begin
			if (!ny[NS][CW-1]) begin
				cx[0] <= ny[NS];
				cy[0] <= -nx[NS];
				ca[0] <= AW'(sik_pkg::HALF_PI_Q30);
			end else begin
				cx[0] <= -ny[NS];
				cy[0] <= nx[NS];
				ca[0] <= -$signed(AW'(sik_pkg::HALF_PI_Q30));
			end
		end else begin
			cx[0] <= nx[NS];
			cy[0] <= ny[NS];
			ca[0] <= '0;
		end
	end

	// Vectoring iterations, one per stage, driving y toward zero.
	for (genvar i = 0; i < CS; i++) begin : g_cordic
		logic signed [CW-1:0] dx, dy;
		logic signed [AW-1:0] step;
		always_comb begin
			dx   = cy[i] >>> i;
			dy   = cx[i] >>> i;
			step = $signed({{(AW - 30){1'b0}}, sik_pkg::ATAN_TAB[i]});
		end
		always_ff @(posedge clk) begin
			cz[i+1] <= cz[i];
			if (!cy[i][CW-1]) begin
				cx[i+1] <= cx[i] + dx;
				cy[i+1] <= cy[i] - dy;
				ca[i+1] <= ca[i] + step;
			end else begin
				cx[i+1] <= cx[i] - dx;
				cy[i+1] <= cy[i] + dy;
				ca[i+1] <= ca[i] - step;
			end
		end
	end

	// The origin has angle zero.
	assign angle = cz[CS] ? '0 : ca[CS];

endmodule

[src/scara_inverse_kinematics_unit.sv]
// Top level of the SCARA inverse kinematics unit: registers, divider, root and angle pipeline.
//
//  Channel   Ports                                          Direction  Transfer
//  target    start, busy, target_x/y/z                      in         start && !busy
//  result    done, joint_one/two_angle, joint_three_travel,  out        done (one cycle)
//            reachable
//  config    cfg_write, cfg_index, cfg_data                 in         cfg_write
//
// A target enters every clock cycle; busy is always low. Each result passes through the
// 31-step restoring divider, the 31-step square root and the 37-stage arctangent units,
// each laid out with one register stage per step.
// Reset clears the valid bits and loads the registers' default lengths.
// The result side cannot stall; results appear in target order, one per target.
module scara_inverse_kinematics_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  target_x,
	input  logic signed [31:0]  target_y,
	input  logic signed [31:0]  target_z,
	output logic                done,
	output logic signed [19:0]  joint_one_angle,
	output logic        [17:0]  joint_two_angle,
	output logic signed [31:0]  joint_three_travel,
	output logic                reachable,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [20:0]         cfg_data
);

	localparam int RND_SHIFT = 30 - FRAC_BITS;
	localparam int SIDE_LAT  = sik_pkg::DIV_STEPS + 1 + sik_pkg::SQRT_STEPS + 2
		+ sik_pkg::ATAN_LAT;
	localparam int LATENCY   = SIDE_LAT + 4;
	localparam int DW        = 44;
	localparam int SW        = 62;
	localparam int AW        = sik_pkg::AW;
	localparam int CW        = sik_pkg::CW;
	localparam logic [63:0] PI_OUT64 =
		(64'(sik_pkg::PI_Q30) + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
	localparam logic [AW-1:0] PI_OUT = AW'(PI_OUT64);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [21:0] a;
		logic        [20:0] b;
		logic               nneg;
		logic               reach;
		logic        [31:0] travel;
	} side_t;

	// Configuration registers.
	logic [20:0] base_height_q, inner_arm_q, outer_arm_q, arm_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= 21'd32768;
			inner_arm_q   <= 21'd16384;
			outer_arm_q   <= 21'd22938;
			arm_width_q   <= 21'd6554;
		end else if (cfg_write) begin
			unique case (sik_pkg::cfg_reg_t'(cfg_index))
				sik_pkg::REG_BASE_HEIGHT: base_height_q <= cfg_data;
				sik_pkg::REG_INNER_ARM:   inner_arm_q   <= cfg_data;
				sik_pkg::REG_OUTER_ARM:   outer_arm_q   <= cfg_data;
				sik_pkg::REG_LINK_WIDTH:  arm_width_q   <= cfg_data;
			endcase
		end
	end

	assign busy = 1'b0;

	// Valid bits of the front stages and of the long delay line.
	logic v_s1, v_s2;
	logic vld_d [SIDE_LAT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k <= SIDE_LAT; k++) vld_d[k] <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			vld_d[0] <= v_s2;
			for (int k = 0; k < SIDE_LAT; k++) vld_d[k+1] <= vld_d[k];
			done <= vld_d[SIDE_LAT];
		end
	end

	// Stage 1: capture the target and the effective arm lengths.
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic signed [21:0] a_s1;
	logic        [20:0] b_s1;
	logic        [22:0] lw_s1;

	always_ff @(posedge clk) begin
		x_s1  <= target_x;
		y_s1  <= target_y;
		z_s1  <= target_z;
		a_s1  <= $signed({1'b0, inner_arm_q}) - $signed({1'b0, arm_width_q});
		b_s1  <= outer_arm_q;
		lw_s1 <= {2'b0, base_height_q} + {1'b0, arm_width_q, 1'b0};
	end

	// Stage 2: squares and the arm product.
	logic        [31:0] ax, ay;
	logic        [20:0] am;
	logic        [63:0] ax2_s2, ay2_s2;
	logic        [41:0] am2_s2, b2_s2, ab_s2;
	logic signed [33:0] trv_s2;
	logic signed [31:0] x_s2, y_s2;
	logic signed [21:0] a_s2;
	logic        [20:0] b_s2;

	always_comb begin
		ax = x_s1[31] ? 32'(-x_s1) : 32'(x_s1);
		ay = y_s1[31] ? 32'(-y_s1) : 32'(y_s1);
		am = a_s1[21] ? 21'(-a_s1) : 21'(a_s1);
	end

	always_ff @(posedge clk) begin
		ax2_s2 <= ax * ax;
		ay2_s2 <= ay * ay;
		am2_s2 <= am * am;
		b2_s2  <= b_s1 * b_s1;
		ab_s2  <= am * b_s1;
		trv_s2 <= $signed({11'b0, lw_s1}) - $signed({{2{z_s1[31]}}, z_s1});
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		a_s2   <= a_s1;
		b_s2   <= b_s1;
	end

	// Stage 3: numerator, divisor, reach test and saturated travel.
	logic [64:0] rsq, nm;
	logic [42:0] lsq, dm;
	logic        nneg, reach;
	logic [31:0] trv_sat;

	always_comb begin
		rsq = {1'b0, ax2_s2} + {1'b0, ay2_s2};
		lsq = {1'b0, am2_s2} + {1'b0, b2_s2};
		dm  = {ab_s2, 1'b0};
		if (rsq >= {22'b0, lsq}) begin
			nm   = rsq - {22'b0, lsq};
			nneg = 1'b0;
		end else begin
			nm   = {22'b0, lsq} - rsq;
			nneg = 1'b1;
		end
		reach = (dm != '0) && (nm <= {22'b0, dm});
		priority if (trv_s2 > 34'sd2147483647) trv_sat = 32'h7FFF_FFFF;
		else if (trv_s2 < -34'sd2147483648)     trv_sat = 32'h8000_0000;
		else                                    trv_sat = trv_s2[31:0];
	end

	side_t side_d [SIDE_LAT+1];

	logic [DW-1:0] rem_d [sik_pkg::DIV_STEPS+1];
	logic [DW-1:0] dm_d  [sik_pkg::DIV_STEPS+1];
	logic [30:0]   quo_d [sik_pkg::DIV_STEPS+1];

	always_ff @(posedge clk) begin
		side_d[0] <= '{x: x_s2, y: y_s2, a: a_s2, b: b_s2, nneg: nneg, reach: reach,
			travel: trv_sat};
		rem_d[0]  <= nm[DW-1:0];
		dm_d[0]   <= {1'b0, dm};
		quo_d[0]  <= '0;
		for (int k = 0; k < SIDE_LAT; k++) side_d[k+1] <= side_d[k];
	end

	// Restoring division, one quotient bit per stage: elbow cosine magnitude in Q30.
	for (genvar k = 0; k < sik_pkg::DIV_STEPS; k++) begin : g_div
		logic [DW-1:0] rin;
		logic          ge;
		always_comb begin
			rin = (k == 0) ? rem_d[k] : (rem_d[k] << 1);
			ge  = rin >= dm_d[k];
		end
		always_ff @(posedge clk) begin
			rem_d[k+1] <= ge ? (rin - dm_d[k]) : rin;
			quo_d[k+1] <= {quo_d[k][29:0], ge};
			dm_d[k+1]  <= dm_d[k];
		end
	end

	// Radicand of the sine: one minus the cosine squared.
	logic [SW-1:0] sq_v  [sik_pkg::SQRT_STEPS+1];
	logic [SW-1:0] sq_r  [sik_pkg::SQRT_STEPS+1];
	logic [30:0]   sq_dq [sik_pkg::SQRT_STEPS+1];

	always_ff @(posedge clk) begin
		sq_v[0]  <= (SW'(1) << 60) - quo_d[sik_pkg::DIV_STEPS] * quo_d[sik_pkg::DIV_STEPS];
		sq_r[0]  <= '0;
		sq_dq[0] <= quo_d[sik_pkg::DIV_STEPS];
	end

	// Digit-by-digit square root, one result bit per stage.
	for (genvar k = 0; k < sik_pkg::SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SW-1:0] BIT = SW'(1) << (60 - 2 * k);
		logic [SW-1:0] t;
		always_comb t = sq_r[k] + BIT;
		always_ff @(posedge clk) begin
			sq_dq[k+1] <= sq_dq[k];
			if (sq_v[k] >= t) begin
				sq_v[k+1] <= sq_v[k] - t;
				sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
			end else begin
				sq_v[k+1] <= sq_v[k];
				sq_r[k+1] <= sq_r[k] >> 1;
			end
		end
	end

	// Stage E: signed cosine and the outer-arm products.
	localparam int SQ_TAP = sik_pkg::DIV_STEPS + 1 + sik_pkg::SQRT_STEPS;
	side_t              se;
	logic               cs_neg;
	logic signed [31:0] cs;
	logic        [30:0] sn_e;
	logic signed [31:0] cs_e;
	logic        [51:0] pn_e;
	logic signed [53:0] pc_e;

	always_comb begin
		se     = side_d[SQ_TAP];
		cs_neg = se.nneg ^ se.a[21];
		cs     = cs_neg ? -$signed({1'b0, sq_dq[sik_pkg::SQRT_STEPS]})
			: $signed({1'b0, sq_dq[sik_pkg::SQRT_STEPS]});
	end

	always_ff @(posedge clk) begin
		sn_e <= sq_r[sik_pkg::SQRT_STEPS][30:0];
		cs_e <= cs;
		pn_e <= se.b * sq_r[sik_pkg::SQRT_STEPS][30:0];
		pc_e <= $signed({1'b0, se.b}) * cs;
	end

	// Stage F: operands of the three arctangents.
	side_t                sf;
	logic signed [CW-1:0] y1_f, x1_f, y2_f, x2_f, ye_f, xe_f;

	always_comb sf = side_d[SQ_TAP + 1];

	always_ff @(posedge clk) begin
		y1_f <= CW'(sf.y);
		x1_f <= CW'(sf.x);
		y2_f <= $signed({4'b0, pn_e});
		x2_f <= $signed({{4{sf.a[21]}}, sf.a, 30'd0}) + CW'(pc_e);
		ye_f <= $signed({25'b0, sn_e});
		xe_f <= CW'(cs_e);
	end

	logic signed [AW-1:0] z_target, z_arm, z_elbow;

	sik_atan2 u_atan_target (.clk(clk), .y_in(y1_f), .x_in(x1_f), .angle(z_target));
	sik_atan2 u_atan_arm    (.clk(clk), .y_in(y2_f), .x_in(x2_f), .angle(z_arm));
	sik_atan2 u_atan_elbow  (.clk(clk), .y_in(ye_f), .x_in(xe_f), .angle(z_elbow));

	// Output stage: rounding to the output format, elbow clamp and unreachable gating.
	side_t              so;
	logic signed [35:0] half, d1, r1, r2;
	logic signed [35:0] e2;

	always_comb begin
		so   = side_d[SIDE_LAT];
		half = 36'sd1 <<< (RND_SHIFT - 1);
		d1   = 36'(z_target) - 36'(z_arm);
		r1   = (d1 + half) >>> RND_SHIFT;
		r2   = (36'(z_elbow) + half) >>> RND_SHIFT;
		priority if (r2 < 0)                             e2 = '0;
		else if (r2 > $signed({2'b0, PI_OUT}))           e2 = $signed({2'b0, PI_OUT});
		else                                             e2 = r2;
	end

	always_ff @(posedge clk) begin
		joint_one_angle    <= so.reach ? r1[19:0] : '0;
		joint_two_angle    <= so.reach ? e2[17:0] : '0;
		joint_three_travel <= so.travel;
		reachable          <= so.reach;
	end

	// Every accepted target yields its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result strobe missing after target transfer");

	// Unreachable targets report zero angles.
	a_unreach: assert property (@(posedge clk) disable iff (!arst_n)
		done && !reachable |-> joint_one_angle == '0 && joint_two_angle == '0)
		else $error("nonzero angle on unreachable target");

	// The elbow angle never exceeds pi.
	a_elbow: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> {16'b0, joint_two_angle} <= PI_OUT)
		else $error("elbow angle above pi");

endmodule

[verif/sik_result_checker.sv]
// Result checker of the SCARA inverse kinematics unit: joint prediction and comparison.
module sik_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic               done,
	input  logic signed [19:0] joint_one_angle,
	input  logic        [17:0] joint_two_angle,
	input  logic signed [31:0] joint_three_travel,
	input  logic               reachable,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [20:0]        cfg_data,
	output int                 mismatch_count,
	output int                 joints_pending,
	output int                 reachable_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [19:0] shoulder;
		logic [17:0] elbow;
		logic [31:0] travel;
		logic        reach;
	} joint_set_t;

	localparam longint NORM_LIMIT = 64'sd1 << 50;

	logic [20:0] base_height, inner_arm, outer_arm, arm_width;
	joint_set_t  joint_queue[$];

	function automatic longint abs_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Round a Q30 angle half up to Q16.
	function automatic longint q30_to_q16(longint v);
		return (v + (64'sd1 <<< 13)) >>> 14;
	endfunction

	// Vectoring CORDIC arctangent with prescaling and quadrant pre-rotation.
	function automatic longint arc_tangent(longint y, longint x);
		longint acc, t, dx, dy;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		while (abs_of(x) < NORM_LIMIT && abs_of(y) < NORM_LIMIT) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; acc = longint'(sik_pkg::HALF_PI_Q30);
			end else begin
				x = -y; y = t; acc = -longint'(sik_pkg::HALF_PI_Q30);
			end
		end
		for (int i = 0; i < sik_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; acc += longint'(sik_pkg::ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; acc -= longint'(sik_pkg::ATAN_TAB[i]);
			end
		end
		return acc;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Joint commands for one target under the current lengths.
	function automatic joint_set_t solve_joints(logic signed [31:0] tx, logic signed [31:0] ty,
			logic signed [31:0] tz);
		longint x, y, z, a, b, cs, sn, num, den, ang1, ang2, pi_q16, travel;
		longint unsigned ax, ay, am, rsq, lsq, dm, nm, rem, dq;
		bit nneg, reach;
		joint_set_t res;
		x = tx; y = ty; z = tz;
		a = longint'(inner_arm) - longint'(arm_width);
		b = longint'(outer_arm);
		ax = abs_of(x); ay = abs_of(y); am = abs_of(a);
		rsq = ax * ax + ay * ay;
		lsq = am * am + longint'(b) * b;
		dm = 2 * am * b;
		ang1 = 0;
		ang2 = 0;
		if (rsq >= lsq) begin
			nm = rsq - lsq; nneg = 0;
		end else begin
			nm = lsq - rsq; nneg = 1;
		end
		reach = (dm != 0) && (nm <= dm);
		if (reach) begin
			rem = nm;
			dq = 0;
			if (rem >= dm) begin
				dq = 1; rem -= dm;
			end
			for (int i = 0; i < 30; i++) begin
				rem <<= 1;
				dq <<= 1;
				if (rem >= dm) begin
					rem -= dm; dq |= 1;
				end
			end
			sn = int_sqrt((64'd1 << 60) - dq * dq);
			cs = (nneg != (a < 0)) ? -longint'(dq) : longint'(dq);
			ang2 = q30_to_q16(arc_tangent(sn, cs));
			pi_q16 = q30_to_q16(longint'(sik_pkg::PI_Q30));
			if (ang2 < 0) ang2 = 0;
			if (ang2 > pi_q16) ang2 = pi_q16;
			num = b * sn;
			den = a * (64'sd1 <<< 30) + b * cs;
			ang1 = q30_to_q16(arc_tangent(y, x) - arc_tangent(num, den));
		end
		travel = longint'(base_height) + 2 * longint'(arm_width) - z;
		if (travel > 64'sd2147483647) travel = 64'sd2147483647;
		if (travel < -64'sd2147483648) travel = -64'sd2147483648;
		res.shoulder = ang1[19:0];
		res.elbow = ang2[17:0];
		res.travel = travel[31:0];
		res.reach = reach;
		return res;
	endfunction

	// Track the registers, queue predictions on each target transfer, check each result.
	always @(posedge clk or negedge arst_n) begin
		joint_set_t want;
		if (!arst_n) begin
			base_height <= 21'd32768;
			inner_arm <= 21'd16384;
			outer_arm <= 21'd22938;
			arm_width <= 21'd6554;
			joint_queue.delete();
			mismatch_count <= 0;
			joints_pending <= 0;
			reachable_seen <= 0;
		end else begin
			if (cfg_write) begin
				case (sik_pkg::cfg_reg_t'(cfg_index))
					sik_pkg::REG_BASE_HEIGHT: base_height <= cfg_data;
					sik_pkg::REG_INNER_ARM:   inner_arm <= cfg_data;
					sik_pkg::REG_OUTER_ARM:   outer_arm <= cfg_data;
					sik_pkg::REG_LINK_WIDTH:  arm_width <= cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				joint_queue = {joint_queue, solve_joints(target_x, target_y, target_z)};
			if (done) begin
				if (joint_queue.size() == 0) begin
					if (mismatch_count < 10)
						$display("ERROR: result with no target outstanding at %0t", $realtime);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = joint_queue.pop_front();
					if (want.reach)
						reachable_seen <= reachable_seen + 1;
					if (want.shoulder !== joint_one_angle || want.elbow !== joint_two_angle
							|| want.travel !== joint_three_travel || want.reach !== reachable) begin
						if (mismatch_count < 10)
							$display({"ERROR: joints mismatch at %0t: expected j1=%0h j2=%0h ",
								"j3=%0h reach=%0b, got j1=%0h j2=%0h j3=%0h reach=%0b"},
								$realtime, want.shoulder, want.elbow, want.travel, want.reach,
								joint_one_angle, joint_two_angle, joint_three_travel, reachable);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			joints_pending <= joint_queue.size();
		end
	end

endmodule

[verif/tb.sv]
// Testbench top of the SCARA inverse kinematics unit: clock, reset, stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic signed [31:0] target_x = 0, target_y = 0, target_z = 0;
	logic               done;
	logic signed [19:0] joint_one_angle;
	logic        [17:0] joint_two_angle;
	logic signed [31:0] joint_three_travel;
	logic               reachable;
	logic               cfg_write = 0;
	logic [1:0]         cfg_index = 0;
	logic [20:0]        cfg_data = 0;
	int                 mismatch_count, joints_pending, reachable_seen;

	// Lengths as last written, used to aim targets into the workspace.
	longint l1 = 32768, l2 = 16384, l3 = 22938, lw = 6554;
	int     targets_sent = 0;
	int     settings_run = 0;
	int     idle_cycles = 0;
	bit     no_gaps = 0;

	always #4 clk = ~clk;

	scara_inverse_kinematics_unit dut (.*);

	sik_result_checker u_checker (.*);

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("scara_inverse_kinematics_unit test failed");
			$finish;
		end
	end

	// One target transfer, after a random gap unless gaps are off.
	task automatic send_target(longint x, longint y, longint z);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		start = 1;
		target_x = x[31:0];
		target_y = y[31:0];
		target_z = z[31:0];
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		@(negedge clk);
		targets_sent++;
	endtask

	task automatic drain_results();
		start = 0;
		while (joints_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all four lengths on consecutive cycles while the unit is idle.
	task automatic set_lengths(longint h, longint inner, longint outer, longint width);
		drain_results();
		cfg_write = 1;
		cfg_index = sik_pkg::REG_BASE_HEIGHT;  cfg_data = h[20:0];     @(negedge clk);
		cfg_index = sik_pkg::REG_INNER_ARM;    cfg_data = inner[20:0]; @(negedge clk);
		cfg_index = sik_pkg::REG_OUTER_ARM;    cfg_data = outer[20:0]; @(negedge clk);
		cfg_index = sik_pkg::REG_LINK_WIDTH;   cfg_data = width[20:0]; @(negedge clk);
		cfg_write = 0;
		l1 = h[20:0]; l2 = inner[20:0]; l3 = outer[20:0]; lw = width[20:0];
		settings_run++;
	endtask

	// Mostly targets inside the annulus the arm reaches, some near its rims, some raw.
	task automatic random_targets(int count);
		longint a, lo, hi, x, y, z, rad;
		real    r, th;
		int     kind;
		a = l2 - lw;
		lo = (a - l3) < 0 ? l3 - a : a - l3;
		hi = (a < 0 ? -a : a) + l3;
		for (int n = 0; n < count; n++) begin
			if (n % 80 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 19);
			z = $signed($urandom);
			if (kind < 3) begin
				x = $signed($urandom);
				y = $signed($urandom);
			end else begin
				if (kind < 6)
					rad = (kind == 3 ? hi : lo) + $signed($urandom_range(0, 8)) - 4;
				else
					rad = lo + longint'($urandom_range(0, 65535)) * (hi - lo) / 65535;
				r = rad;
				th = ($urandom_range(0, 1000000) / 1000000.0) * 6.283185307 - 3.1415926535;
				x = $rtoi(r * $cos(th));
				y = $rtoi(r * $sin(th));
				if (kind == 19) begin
					x = 0; y = rad;
				end
			end
			send_target(x, y, z);
			if (n == count / 2 && settings_run == 0)
				drain_results();
		end
		no_gaps = 0;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed targets on the reset lengths.
		send_target(0, 0, 0);
		send_target(64'sd2147483647, 0, 0);
		send_target(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647);
		send_target(0, 64'sd2147483647, -64'sd2147483648);
		send_target(l2 - lw + l3, 0, 0);
		send_target(-(l2 - lw + l3), 0, 0);
		send_target(0, l3 - (l2 - lw), 0);
		send_target(0, -(l2 - lw + l3), 0);
		send_target(l2 - lw + l3 + 1, 0, 0);
		send_target(-20000, -15000, 65536);
		random_targets(250);

		// Zero lengths: the divisor vanishes everywhere.
		set_lengths(0, 0, 0, 0);
		send_target(0, 0, -64'sd2147483648);
		random_targets(25);

		// Every register at its top code: no inner arm left, travel at its largest.
		set_lengths(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF);
		send_target(0, 0, -64'sd2147483648);
		random_targets(25);

		// Equal arms of 1048576 with no width.
		set_lengths(21'h1FFFFF, 1048576, 1048576, 0);
		send_target(2097152, 0, 64'sd2147483647);
		send_target(0, 0, 0);
		random_targets(250);

		// Width beyond the inner arm: negative effective inner arm.
		set_lengths(50000, 10000, 20000, 40000);
		send_target(50000, 0, 0);
		send_target(-10000, 0, 0);
		random_targets(250);

		// Equal effective arms: the folded elbow puts the wrist on the origin.
		set_lengths(65536, 30000, 24000, 6000);
		send_target(0, 0, 0);
		send_target(48000, 0, 0);
		random_targets(250);

		// Random lengths within their ranges.
		for (int p = 0; p < 3; p++) begin
			set_lengths($urandom_range(0, 1048576), $urandom_range(1, 1048576),
				$urandom_range(1, 1048576), $urandom_range(0, 1048576));
			random_targets(100);
		end

		drain_results();
		repeat (120) @(negedge clk);
		$display("Sent %0d targets over %0d length settings; %0d results were reachable.",
			targets_sent, settings_run + 1, reachable_seen);
		$display("Covered zero divisor, negative inner arm, folded and stretched arm, saturation.");
		if (mismatch_count == 0 && joints_pending == 0) begin
			$display("scara_inverse_kinematics_unit test passed");
		end else begin
			$display("scara_inverse_kinematics_unit test failed");
		end
		$finish;
	end

endmodule
